[rtl/s2d_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII converter.
package s2d_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = 4;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int QUOT_W     = VALUE_W - 3;

    // Multiply by this and shift right by 35 to divide a 32-bit value by ten
    localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    localparam logic [CNT_W-1:0] LAST_DIGIT_IDX = 4'd9;

    typedef logic [DIGIT_W-1:0] t_digit;

    // One classified number: sign flag and unsigned magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

endpackage

[rtl/s2d_front.sv]
// Input side: accepts integers and splits them into sign and magnitude.
module s2d_front (
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [31:0]              i_s_tdata,
    output logic                     o_push_valid,
    input  logic                     i_push_ready,
    output s2d_pkg::t_item           o_push_item
);
    import s2d_pkg::*;

    logic w_neg;

    // Classify sign and form the magnitude modulo 2^32
    assign w_neg             = i_s_tdata[VALUE_W-1];
    assign o_push_item.neg   = w_neg;
    assign o_push_item.mag   = w_neg ? (VALUE_W'(0) - i_s_tdata) : i_s_tdata;

    // Pass the handshake through to the queue
    assign o_push_valid = i_s_tvalid;
    assign o_s_tready   = i_push_ready;

endmodule

[rtl/s2d_queue.sv]
// Small FIFO of classified numbers between the front and back parts.
module s2d_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  s2d_pkg::t_item i_push_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output s2d_pkg::t_item o_pop_item
);
    import s2d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          w_push, w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Advance pointers with wrap and track the fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill level above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue fill level did not follow a push");

endmodule

[rtl/s2d_back.sv]
// Output side: divides the magnitude into digits and emits the characters.
module s2d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  s2d_pkg::t_item i_pop_item,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,
    output logic           o_m_tlast
);
    import s2d_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic               r_neg, n_neg;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_digit             r_dig [NUM_DIGITS];
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_out_last, n_out_last;

    logic [PROD_W-1:0]  w_prod;
    logic [QUOT_W-1:0]  w_quot;
    logic [VALUE_W-1:0] w_q10;
    logic [VALUE_W-1:0] w_rem;
    logic               w_dig_we;
    logic               w_slot_free;

    // Divide by ten through the reciprocal, remainder by subtraction
    assign w_prod = {{VALUE_W{1'b0}}, r_mag} * {{VALUE_W{1'b0}}, RECIP_10};
    assign w_quot = w_prod[PROD_W-1:35];
    assign w_q10  = {w_quot, 3'b000} + {2'b00, w_quot, 1'b0};
    assign w_rem  = r_mag - w_q10;

    assign w_slot_free = !r_out_valid || i_m_tready;

    // Sequence: load, collect digits low first, emit sign and digits high first
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_dig_we    = 1'b0;
        o_pop_ready = 1'b0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_mag   = i_pop_item.mag;
                    n_neg   = i_pop_item.neg;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                w_dig_we = 1'b1;
                n_mag    = {3'b000, w_quot};
                if (w_quot == '0 || r_cnt == LAST_DIGIT_IDX) begin
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_out_char = CHAR_MINUS;
                        n_out_last = 1'b0;
                        n_neg      = 1'b0;
                    end else begin
                        n_out_char = CHAR_ZERO + {4'b0000, r_dig[r_cnt]};
                        n_out_last = (r_cnt == '0);
                        if (r_cnt == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_cnt = r_cnt - CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_neg       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_neg       <= n_neg;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload: magnitude, digit store and output character
    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        if (w_dig_we) begin
            r_dig[r_cnt] <= w_rem[DIGIT_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

    a_rem_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (w_rem < VALUE_W'(10)))
        else $error("reciprocal division left a remainder of ten or more");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt <= LAST_DIGIT_IDX))
        else $error("digit index out of range while emitting");

    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_char != CHAR_MINUS))
        else $error("minus sign marked as final character");

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Each accepted 32-bit two's-complement integer comes out as its decimal
// characters, most significant first, one per output transaction: a '-'
// for a negative value, then the digits without leading zeros ('0' for
// zero); tlast marks the final character. The back part divides the
// magnitude by ten once per digit (a 32x32 reciprocal multiply), storing
// the digits low first, then emits the characters high first. It takes a
// new number only when idle. A queue of QUEUE_DEPTH entries lets the input
// side keep accepting numbers while the back part is busy, until it is full.
module signed_int_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] char_code
    output logic        o_m_axis_tlast    // last_char
);
    import s2d_pkg::*;

    logic  w_push_valid, w_push_ready;
    t_item w_push_item;
    logic  w_pop_valid, w_pop_ready;
    t_item w_pop_item;

    // Accept and classify
    s2d_front u_front (
        .i_s_tvalid   (i_s_axis_tvalid),
        .o_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_item  (w_push_item)
    );

    // Decouple the two sides
    s2d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_item  (w_push_item),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_item   (w_pop_item)
    );

    // Convert and emit characters
    s2d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_item  (w_pop_item),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast)
    );

endmodule

[bench/tb_signed_int_to_decimal_ascii.sv]
// Self-checking testbench for the signed 32-bit integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    import s2d_pkg::*;

    // One expected output character with its end-of-number mark
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_ascii_char;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_CYCLES = 300;
    localparam int REPORT_LIMIT = 10;

    // Corner values: zero, single digits, decade edges, both extremes, bit patterns
    localparam logic [VALUE_W-1:0] CORNER_VALUES [0:19] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd5, 32'd9, 32'd10, -32'd10, 32'd99,
        32'd100, -32'd101, 32'd12345, -32'd54321, 32'd999999999, 32'd1000000000,
        -32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
        32'h5555_5555, 32'hAAAA_AAAA
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [VALUE_W-1:0] i_s_axis_tdata = '0;   // [31:0] value
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]  o_m_axis_tdata;        // [7:0] char_code
    logic               o_m_axis_tlast;        // last_char

    logic [VALUE_W-1:0] pending_values [$];
    t_ascii_char        expected_chars [$];

    logic in_taken = 1'b0;
    logic sink_blocked = 1'b0;
    logic stall_armed = 1'b0;
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    int   mismatches = 0;
    int   numbers_taken = 0;
    int   negatives_taken = 0;
    int   chars_checked = 0;

    signed_int_to_decimal_ascii dut (.*);

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predict the characters of one number and queue them
    task automatic push_expected_chars(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digits [0:NUM_DIGITS-1];
        int                 count;
        t_ascii_char        ch;
        magnitude = value[VALUE_W-1] ? (~value + 32'd1) : value;
        count = 0;
        do begin
            digits[count] = 4'(magnitude % 32'd10);
            magnitude = magnitude / 32'd10;
            count++;
        end while (magnitude != 0 && count < NUM_DIGITS);
        if (value[VALUE_W-1]) begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int i = count - 1; i >= 0; i--) begin
            ch.code = CHAR_ZERO + CHAR_W'(digits[i]);
            ch.last = (i == 0);
            expected_chars.push_back(ch);
        end
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
        end
    endtask

    // Random number with a random digit count, so short and long numbers both appear
    function automatic logic [VALUE_W-1:0] random_number();
        int unsigned        digit_count;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] mag;
        if ($urandom_range(0, 3) == 0) begin
            return $urandom();
        end
        digit_count = $urandom_range(1, 10);
        lo = 32'd1;
        repeat (digit_count - 1) lo = lo * 10;
        hi = (digit_count == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
        mag = $urandom_range(hi, lo);
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    // Wait until every queued number has been sent and fully printed
    task automatic wait_until_drained();
        while (pending_values.size() != 0 || i_s_axis_tvalid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random_phase(input int count, input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (count) pending_values.push_back(random_number());
        wait_until_drained();
    endtask

    // Input driver: offer the next pending number, hold it until the transaction completes
    always @(negedge i_clk) begin : number_driver
        logic [VALUE_W-1:0] next_value;
        if (i_rst_n && (!i_s_axis_tvalid || in_taken)) begin
            if (pending_values.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_value = pending_values.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= next_value;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output ready: random back-pressure plus the long stall
    always @(negedge i_clk) begin
        i_m_axis_tready <= i_rst_n && !sink_blocked && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Monitor: record accepted numbers and check every output character
    always @(posedge i_clk) begin : char_monitor
        t_ascii_char want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected character %0d (last %0b)",
                                 $realtime, o_m_axis_tdata, o_m_axis_tlast);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (o_m_axis_tdata !== want.code) begin
                        note_mismatch("char_code", int'(want.code), int'(o_m_axis_tdata));
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        note_mismatch("last_char", int'(want.last), int'(o_m_axis_tlast));
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                push_expected_chars(i_s_axis_tdata);
                numbers_taken++;
                if (i_s_axis_tdata[VALUE_W-1]) negatives_taken++;
            end
        end
    end

    // Long output stall while the sender keeps offering numbers
    initial begin : output_stall
        wait (stall_armed);
        @(posedge i_clk);
        sink_blocked <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        sink_blocked <= 1'b0;
    end

    // Stimulus sequence
    initial begin : stimulus
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners with light idling
        src_idle_pct = 30;
        snk_idle_pct = 30;
        foreach (CORNER_VALUES[i]) pending_values.push_back(CORNER_VALUES[i]);
        wait_until_drained();

        // Random numbers under three idle profiles
        run_random_phase(80, 22, 80);
        run_random_phase(80, 80, 22);
        stall_armed = 1'b1;
        run_random_phase(90, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers (%0d negative) into %0d checked characters,",
                 numbers_taken, negatives_taken, chars_checked);
        $display("covering zero, both 32-bit extremes, three idle profiles and a %0d-cycle stall.",
                 STALL_CYCLES);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Timeout
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
